FILE: design/icmp_echo_responder_macros.svh
// Assertion macros of the ICMP echo responder, used by icmp_ctrl.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ICMP_ECHO_RESPONDER_MACROS_SVH
`define ICMP_ECHO_RESPONDER_MACROS_SVH
`ifndef SYNTH
`define ICMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ICMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ICMP_ASSERT_IMP(lbl, ante, cons, msg)
`define ICMP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/icmp_pkg.sv
// Shared types, constants and functions of the ICMP echo responder.
// Used by icmp_dp, icmp_ctrl and icmp_echo_responder; depends on nothing.
package icmp_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_BYTES);

  localparam int ETH_HDR = 14;
  localparam int SRC_MAC_ADDR = 6;
  localparam int SRC_IP_ADDR = 26;
  localparam int ICMP_LEN = 64;
  localparam int ICMP_DATA_OFS = 4;
  localparam int MIN_FRAME = ETH_HDR + 1;
  localparam int IHL_MIN = 5;
  localparam logic [6:0] SCAN_LAST = 7'd67;
  localparam logic [7:0] ECHO_REQ = 8'h08;
  localparam logic [7:0] ECHO_CODE = 8'h00;
  localparam logic [15:0] IP_SUM_SEED = 16'h8456;

  localparam logic [5:0] W_DST_MAC2 = 6'd2;
  localparam logic [5:0] W_SRC_MAC0 = 6'd3;
  localparam logic [5:0] W_SRC_MAC1 = 6'd4;
  localparam logic [5:0] W_SRC_MAC2 = 6'd5;
  localparam logic [5:0] W_ETYPE = 6'd6;
  localparam logic [5:0] W_VER = 6'd7;
  localparam logic [5:0] W_LEN = 6'd8;
  localparam logic [5:0] W_ID = 6'd9;
  localparam logic [5:0] W_FLAGS = 6'd10;
  localparam logic [5:0] W_TTL = 6'd11;
  localparam logic [5:0] W_IP_CK = 6'd12;
  localparam logic [5:0] W_SRC_IP0 = 6'd13;
  localparam logic [5:0] W_SRC_IP1 = 6'd14;
  localparam logic [5:0] W_DST_IP0 = 6'd15;
  localparam logic [5:0] W_DST_IP1 = 6'd16;
  localparam logic [5:0] W_TYPE = 6'd17;
  localparam logic [5:0] W_ICMP_CK = 6'd18;
  localparam logic [5:0] W_DATA0 = 6'd19;
  localparam logic [5:0] WORD_LAST = 6'd48;

  localparam logic REG_LOCAL_MAC = 1'b0;
  localparam logic REG_LOCAL_IP = 1'b1;

  localparam logic [1:0] A_IHL = 2'd0;
  localparam logic [1:0] A_SCAN = 2'd1;
  localparam logic [1:0] A_WORD = 2'd2;

  typedef struct packed {
    logic       rx_take;
    logic [1:0] asel;
    logic [6:0] idx;
    logic       half;
    logic       ic_load;
    logic       scan_v;
    logic       hi_load;
    logic       word_load;
    logic       id_inc;
  } icmp_cmd_t;

  typedef struct packed {
    logic len_ok;
    logic hdr_ok;
    logic echo_ok;
  } icmp_stat_t;

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? (s[15:0] + 16'd1) : s[15:0];
  endfunction

endpackage

FILE: design/icmp_dp.sv
// Datapath of the ICMP echo responder: frame memory, checksum adders, reply words.
// Depends on icmp_pkg; driven by icmp_ctrl through icmp_cmd_t.
module icmp_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  icmp_pkg::icmp_cmd_t  cmd,
  output icmp_pkg::icmp_stat_t stat,
  input  logic [7:0]           rx_byte,
  input  logic                 rx_last,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [47:0]          cfg_data,
  output logic [15:0]          tx_word
);

  logic [7:0]  mem [icmp_pkg::FRAME_BYTES];
  logic [icmp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, n_after, n_r;
  logic [icmp_pkg::ADDR_W-1:0] raddr;
  logic [7:0]  rd_q_r, hi_r;
  logic [6:0]  ic_r, ic_nxt;
  logic [7:0]  need;
  logic [3:0]  ihl;
  logic [6:0]  k_d_r;
  logic        scan_v_d_r;
  logic [15:0] ip_acc_r, icmp_acc_r, ip_op, id_r, out_word_r, word_nxt;
  logic        ip_add;
  logic        type_ok_r, code_ok_r;
  logic [47:0] mac_r;
  logic [31:0] ip_r;
  logic [7:0]  wh;
  logic        full;

  assign full = (cnt_r == icmp_pkg::CNT_W'(icmp_pkg::FRAME_BYTES));
  assign n_after = full ? cnt_r : cnt_r + icmp_pkg::CNT_W'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.rx_take) begin
      cnt_nxt = rx_last ? '0 : n_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_take && !full) begin
      mem[cnt_r[icmp_pkg::ADDR_W-1:0]] <= rx_byte;
    end
    if (cmd.rx_take && rx_last) begin
      n_r <= n_after;
    end
    rd_q_r <= mem[raddr];
  end

  assign wh = {cmd.idx, cmd.half};

  always_comb begin
    case (cmd.asel)
      icmp_pkg::A_SCAN: begin
        if (cmd.idx[6]) begin
          raddr = icmp_pkg::ADDR_W'(icmp_pkg::SRC_IP_ADDR) + icmp_pkg::ADDR_W'(cmd.idx[1:0]);
        end else begin
          raddr = icmp_pkg::ADDR_W'(ic_r) + icmp_pkg::ADDR_W'(cmd.idx[5:0]);
        end
      end
      icmp_pkg::A_WORD: begin
        if (cmd.idx[5:0] <= icmp_pkg::W_DST_MAC2) begin
          raddr = icmp_pkg::ADDR_W'(icmp_pkg::SRC_MAC_ADDR) + icmp_pkg::ADDR_W'(wh);
        end else if (cmd.idx[5:0] < icmp_pkg::W_TYPE) begin
          raddr = icmp_pkg::ADDR_W'(wh) + icmp_pkg::ADDR_W'(icmp_pkg::SRC_IP_ADDR)
                  - icmp_pkg::ADDR_W'({icmp_pkg::W_DST_IP0, 1'b0});
        end else begin
          raddr = icmp_pkg::ADDR_W'(ic_r) + icmp_pkg::ADDR_W'(wh)
                  + icmp_pkg::ADDR_W'(icmp_pkg::ICMP_DATA_OFS)
                  - icmp_pkg::ADDR_W'({icmp_pkg::W_DATA0, 1'b0});
        end
      end
      default: raddr = icmp_pkg::ADDR_W'(icmp_pkg::ETH_HDR);
    endcase
  end

  assign ihl = rd_q_r[3:0];
  assign ic_nxt = 7'(icmp_pkg::ETH_HDR) + {1'b0, ihl, 2'b00};
  assign need = {1'b0, ic_nxt} + 8'(icmp_pkg::ICMP_LEN);

  assign stat.len_ok = (n_after >= icmp_pkg::CNT_W'(icmp_pkg::MIN_FRAME));
  assign stat.hdr_ok = (ihl >= 4'(icmp_pkg::IHL_MIN)) && (n_r >= icmp_pkg::CNT_W'(need));
  assign stat.echo_ok = type_ok_r && code_ok_r;

  always_comb begin
    ip_add = 1'b0;
    ip_op = {hi_r, rd_q_r};
    if (scan_v_d_r && k_d_r[6] && k_d_r[0]) begin
      ip_add = 1'b1;
    end else if (cmd.scan_v && cmd.idx < 7'd3) begin
      ip_add = 1'b1;
      case (cmd.idx[1:0])
        2'd0: ip_op = {id_r[7:0], id_r[15:8]};
        2'd1: ip_op = ip_r[31:16];
        default: ip_op = ip_r[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scan_v_d_r <= cmd.scan_v;
    k_d_r <= cmd.idx;
    if (cmd.ic_load) begin
      ic_r <= ic_nxt;
      ip_acc_r <= icmp_pkg::IP_SUM_SEED;
      icmp_acc_r <= '0;
    end else begin
      if (ip_add) begin
        ip_acc_r <= icmp_pkg::oc_add(ip_acc_r, ip_op);
      end
      if (scan_v_d_r && !k_d_r[6] && k_d_r[0] && k_d_r[5:0] > 6'd3) begin
        icmp_acc_r <= icmp_pkg::oc_add(icmp_acc_r, {hi_r, rd_q_r});
      end
    end
    if ((scan_v_d_r && !k_d_r[0]) || cmd.hi_load) begin
      hi_r <= rd_q_r;
    end
    if (scan_v_d_r && k_d_r == 7'd0) begin
      type_ok_r <= (rd_q_r == icmp_pkg::ECHO_REQ);
    end
    if (scan_v_d_r && k_d_r == 7'd1) begin
      code_ok_r <= (rd_q_r == icmp_pkg::ECHO_CODE);
    end
    if (cmd.word_load) begin
      out_word_r <= word_nxt;
    end
  end

  always_comb begin
    case (cmd.idx[5:0])
      icmp_pkg::W_SRC_MAC0: word_nxt = mac_r[47:32];
      icmp_pkg::W_SRC_MAC1: word_nxt = mac_r[31:16];
      icmp_pkg::W_SRC_MAC2: word_nxt = mac_r[15:0];
      icmp_pkg::W_ETYPE:    word_nxt = 16'h0800;
      icmp_pkg::W_VER:      word_nxt = 16'h4500;
      icmp_pkg::W_LEN:      word_nxt = 16'(20 + icmp_pkg::ICMP_LEN);
      icmp_pkg::W_ID:       word_nxt = {id_r[7:0], id_r[15:8]};
      icmp_pkg::W_FLAGS:    word_nxt = 16'h4000;
      icmp_pkg::W_TTL:      word_nxt = 16'hFF01;
      icmp_pkg::W_IP_CK:    word_nxt = ~ip_acc_r;
      icmp_pkg::W_SRC_IP0:  word_nxt = ip_r[31:16];
      icmp_pkg::W_SRC_IP1:  word_nxt = ip_r[15:0];
      icmp_pkg::W_TYPE:     word_nxt = 16'h0000;
      icmp_pkg::W_ICMP_CK:  word_nxt = ~icmp_acc_r;
      default:              word_nxt = {hi_r, rd_q_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= '0;
      mac_r <= '0;
      ip_r <= '0;
    end else begin
      if (cmd.id_inc) begin
        id_r <= id_r + 16'd1;
      end
      if (cfg_we && cfg_index == icmp_pkg::REG_LOCAL_MAC) begin
        mac_r <= cfg_data;
      end
      if (cfg_we && cfg_index == icmp_pkg::REG_LOCAL_IP) begin
        ip_r <= cfg_data[31:0];
      end
    end
  end

  assign tx_word = out_word_r;

endmodule

FILE: design/icmp_ctrl.sv
// Controller of the ICMP echo responder: frame intake, header check, scan and reply.
// Depends on icmp_pkg and icmp_echo_responder_macros.svh; drives icmp_dp.
`include "icmp_echo_responder_macros.svh"
module icmp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 rx_last,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 tx_last,
  input  icmp_pkg::icmp_stat_t stat,
  output icmp_pkg::icmp_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_IHL_RD = 4'd1;
  localparam logic [3:0] S_IHL_EV = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_SCAN_END = 4'd4;
  localparam logic [3:0] S_WRD0 = 4'd5;
  localparam logic [3:0] S_WRD1 = 4'd6;
  localparam logic [3:0] S_WRD2 = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [6:0] k_r, k_nxt;
  logic [5:0] w_r, w_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;
    w_nxt = w_r;
    cmd = '0;
    cmd.asel = icmp_pkg::A_IHL;
    case (state_r)
      S_IDLE: begin
        cmd.rx_take = in_valid;
        if (in_valid && rx_last && stat.len_ok) begin
          state_nxt = S_IHL_RD;
        end
      end
      S_IHL_RD: begin
        state_nxt = S_IHL_EV;
      end
      S_IHL_EV: begin
        if (stat.hdr_ok) begin
          cmd.ic_load = 1'b1;
          k_nxt = '0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.asel = icmp_pkg::A_SCAN;
        cmd.idx = k_r;
        cmd.scan_v = 1'b1;
        k_nxt = k_r + 7'd1;
        if (k_r == icmp_pkg::SCAN_LAST) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        w_nxt = '0;
        state_nxt = stat.echo_ok ? S_WRD0 : S_IDLE;
      end
      S_WRD0: begin
        cmd.asel = icmp_pkg::A_WORD;
        cmd.idx = {1'b0, w_r};
        state_nxt = S_WRD1;
      end
      S_WRD1: begin
        cmd.asel = icmp_pkg::A_WORD;
        cmd.idx = {1'b0, w_r};
        cmd.half = 1'b1;
        cmd.hi_load = 1'b1;
        state_nxt = S_WRD2;
      end
      S_WRD2: begin
        cmd.idx = {1'b0, w_r};
        cmd.word_load = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (w_r == icmp_pkg::WORD_LAST) begin
            cmd.id_inc = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            w_nxt = w_r + 6'd1;
            state_nxt = S_WRD0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r <= '0;
      w_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      w_r <= w_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign tx_last = (w_r == icmp_pkg::WORD_LAST);

  `ICMP_ASSERT_NXT(a_short_drop, state_r == S_IDLE && in_valid && rx_last && !stat.len_ok, state_r == S_IDLE, "short frame not dropped")
  `ICMP_ASSERT_NXT(a_hold_word, out_valid && out_stall, out_valid && $stable(w_r), "stalled reply word moved")
  `ICMP_ASSERT_NXT(a_scan_end, state_r == S_SCAN && k_r == icmp_pkg::SCAN_LAST, state_r == S_SCAN_END, "scan did not end")
  `ICMP_ASSERT_IMP(a_id_last, cmd.id_inc, tx_last && out_valid && !out_stall, "id advanced off last word")

endmodule

FILE: design/icmp_echo_responder.sv
// Top level of the ICMP echo responder: joins icmp_ctrl and icmp_dp.
// Depends on icmp_pkg, icmp_ctrl and icmp_dp.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | in_rx_byte[7:0], in_rx_last
//  out     | out_valid/out_stall| out_tx_word[15:0], out_tx_last
//  cfg     | cfg_valid/cfg_ready| cfg_index (0 MAC, 1 IP), cfg_data[47:0]
//
// Frame bytes are taken one per cycle while in_stall is low, into a 256-byte frame memory.
// After the last byte of a long enough frame the block stalls input for a header check, then
// a checksum scan over the memory's single read port, then 49 reply words if no check fails.
// Each reply word waits in the output register as long as out_stall is high.
// Reset is synchronous; it clears the byte count, the id counter and the config registers.
module icmp_echo_responder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_tx_word,
  output logic        out_tx_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  icmp_pkg::icmp_cmd_t  cmd;
  icmp_pkg::icmp_stat_t stat;

  assign cfg_ready = 1'b1;

  icmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .rx_last   (in_rx_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_last   (out_tx_last),
    .stat      (stat),
    .cmd       (cmd)
  );

  icmp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .rx_byte   (in_rx_byte),
    .rx_last   (in_rx_last),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tx_word   (out_tx_word)
  );

endmodule
